[hdl/hfpp_pkg.sv]
// Shared types, character codes and the hex-digit decode for the frame pair parser.
`default_nettype none

package hfpp_pkg;

    // Character codes of the serial protocol
    localparam logic [7:0] TAG_FIRST = 8'h67;  // 'g'
    localparam logic [7:0] TAG_LAST  = 8'h7A;  // 'z'
    localparam logic [7:0] TAG_CUR_L = 8'h69;  // 'i'
    localparam logic [7:0] TAG_CUR_R = 8'h6A;  // 'j'
    localparam logic [7:0] TAG_ODO_L = 8'h6C;  // 'l'
    localparam logic [7:0] TAG_ODO_R = 8'h72;  // 'r'
    localparam logic [7:0] DIG_0     = 8'h30;  // '0'
    localparam logic [7:0] DIG_9     = 8'h39;  // '9'
    localparam logic [7:0] DIG_A     = 8'h41;  // 'A'
    localparam logic [7:0] DIG_F     = 8'h46;  // 'F'

    // Frame position: no frame open, then tag plus 0..3 digits gathered
    localparam logic [2:0] POS_IDLE  = 3'd0;
    localparam logic [2:0] POS_FIRST = 3'd1;
    localparam logic [2:0] POS_LAST  = 3'd4;

    // Pair kinds on the result channel
    localparam logic PAIR_CURRENT  = 1'b0;
    localparam logic PAIR_ODOMETRY = 1'b1;

    // Channel class of a tag byte; any tag not listed is a dropped channel
    typedef enum logic [2:0] {
        CH_OTHER,
        CH_CUR_L,
        CH_CUR_R,
        CH_ODO_L,
        CH_ODO_R
    } t_chan;

    // Classified byte passed from the front to the back
    typedef struct packed {
        logic       is_tag;
        t_chan      chan;
        logic [3:0] nib;
    } t_tok;

    // Decode one byte as an upper-case hex digit; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= DIG_0 && b <= DIG_9) begin
            d = b - DIG_0;
        end else if (b >= DIG_A && b <= DIG_F) begin
            d = b - DIG_A + 8'd10;
        end
        return d[3:0];
    endfunction

    // Map a tag byte onto its channel class
    function automatic t_chan chan_of(input logic [7:0] b);
        t_chan c;
        unique case (b)
            TAG_CUR_L: c = CH_CUR_L;
            TAG_CUR_R: c = CH_CUR_R;
            TAG_ODO_L: c = CH_ODO_L;
            TAG_ODO_R: c = CH_ODO_R;
            default:   c = CH_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/hex_frame_pair_parser_unit.sv]
// Hex frame pair parser: top level joining front end, token queue and back end.
//
// Input channel: one received byte per beat on i_rx_byte, qualified by
// i_in_valid and held off by o_in_stall. Tag bytes 'g'..'z' open a frame;
// the next four bytes are upper-case hex digits of a 16-bit value.
// Output channel: one pair per beat on o_pair_kind, o_left_value and
// o_right_value, qualified by o_out_valid and held off by i_out_stall.
// A pair is produced when a right frame ('j' or 'r') completes while its
// left value ('i' or 'l') is pending.
// Throughput: one byte per cycle while o_in_stall is low. The back end retires one token per cycle
// while the result register is free or being drained.
// Path: the byte completing a right frame is written into the token queue,
// then retired by the back end into the result register; tokens still
// waiting ahead of it in the queue are retired first.
// When the receiver stalls, the result register holds its beat, the back end
// stops, and the QUEUE_DEPTH-entry token queue absorbs further bytes before
// o_in_stall rises.
// Reset (synchronous, active low) closes any frame, clears the pending left
// values and empties the queue and the result register.
`default_nettype none

module hex_frame_pair_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_pair_kind,
    output logic [15:0]      o_left_value,
    output logic [15:0]      o_right_value
);

    hfpp_pkg::t_tok w_in_tok;
    hfpp_pkg::t_tok w_head;
    logic           w_push;
    logic           w_pop;
    logic           w_head_valid;
    logic           w_full;

    // Classify incoming bytes
    hfpp_front u_front (
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_full),
        .o_tok      (w_in_tok),
        .o_push     (w_push),
        .o_in_stall (o_in_stall)
    );

    // Buffer tokens between the two halves
    hfpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_tok        (w_in_tok),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    // Track frames and emit pairs
    hfpp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok         (w_head),
        .i_tok_valid   (w_head_valid),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pair_kind   (o_pair_kind),
        .o_left_value  (o_left_value),
        .o_right_value (o_right_value)
    );

`ifndef SYNTHESIS
    // A fresh result only follows a token retired by the back end
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop))
        else $error("result appeared without a retired token");

    // An accepted byte is queued for the back end on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_head_valid)
        else $error("accepted byte missing from the queue");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid directly after reset");
`endif

endmodule

`default_nettype wire

[hdl/hfpp_front.sv]
// Front end: accepts received bytes and classifies each one into a tag or digit token.
`default_nettype none

module hfpp_front (
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output hfpp_pkg::t_tok     o_tok,
    output logic               o_push,
    output logic               o_in_stall
);

    logic w_is_tag;

    // Classify the byte: tags open a frame, everything else is a digit candidate
    assign w_is_tag = (i_rx_byte >= hfpp_pkg::TAG_FIRST) && (i_rx_byte <= hfpp_pkg::TAG_LAST);

    always_comb begin
        o_tok.is_tag = w_is_tag;
        o_tok.chan   = w_is_tag ? hfpp_pkg::chan_of(i_rx_byte) : hfpp_pkg::CH_OTHER;
        o_tok.nib    = w_is_tag ? 4'd0 : hfpp_pkg::hex_nibble(i_rx_byte);
    end

    // Hold the sender off while the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

`default_nettype wire

[hdl/hfpp_queue.sv]
// Short token queue that decouples the byte front end from the frame back end.
`default_nettype none

module hfpp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hfpp_pkg::t_tok i_tok,
    input  wire logic          i_pop,
    output hfpp_pkg::t_tok     o_head,
    output logic               o_head_valid,
    output logic               o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hfpp_pkg::t_tok r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == FULL_CNT);

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming token
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

`default_nettype wire

[hdl/hfpp_back.sv]
// Back end: frame tracking, hex accumulation, left-value stores and the result register.
`default_nettype none

module hfpp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hfpp_pkg::t_tok i_tok,
    input  wire logic          i_tok_valid,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_pair_kind,
    output logic [15:0]        o_left_value,
    output logic [15:0]        o_right_value
);

    logic [2:0]      r_pos,      n_pos;
    hfpp_pkg::t_chan r_chan,     n_chan;
    logic [15:0]     r_acc,      n_acc;
    logic            r_cur_pend, n_cur_pend;
    logic [15:0]     r_cur_left, n_cur_left;
    logic            r_odo_pend, n_odo_pend;
    logic [15:0]     r_odo_left, n_odo_left;
    logic            r_out_valid, n_out_valid;
    logic            r_kind,     n_kind;
    logic [15:0]     r_left,     n_left;
    logic [15:0]     r_right,    n_right;
    logic [15:0]     w_value;
    logic            w_emit;

    // Take a token whenever the result register is free or being drained
    assign o_pop   = i_tok_valid && (!r_out_valid || !i_out_stall);
    assign w_value = {r_acc[11:0], i_tok.nib};

    always_comb begin
        n_pos      = r_pos;
        n_chan     = r_chan;
        n_acc      = r_acc;
        n_cur_pend = r_cur_pend;
        n_cur_left = r_cur_left;
        n_odo_pend = r_odo_pend;
        n_odo_left = r_odo_left;
        n_kind     = r_kind;
        n_left     = r_left;
        n_right    = r_right;
        w_emit     = 1'b0;
        if (o_pop) begin
            if (i_tok.is_tag) begin
                // Open a fresh frame, dropping any frame in progress
                n_chan = i_tok.chan;
                n_acc  = '0;
                n_pos  = hfpp_pkg::POS_FIRST;
            end else if (r_pos != hfpp_pkg::POS_IDLE) begin
                n_acc = w_value;
                if (r_pos == hfpp_pkg::POS_LAST) begin
                    // Frame complete: store a left value or pair up a right one
                    n_pos = hfpp_pkg::POS_IDLE;
                    unique case (r_chan)
                        hfpp_pkg::CH_CUR_L: begin
                            n_cur_left = w_value;
                            n_cur_pend = 1'b1;
                        end
                        hfpp_pkg::CH_CUR_R: begin
                            if (r_cur_pend) begin
                                n_cur_pend = 1'b0;
                                w_emit     = 1'b1;
                                n_kind     = hfpp_pkg::PAIR_CURRENT;
                                n_left     = r_cur_left;
                                n_right    = w_value;
                            end
                        end
                        hfpp_pkg::CH_ODO_L: begin
                            n_odo_left = w_value;
                            n_odo_pend = 1'b1;
                        end
                        hfpp_pkg::CH_ODO_R: begin
                            if (r_odo_pend) begin
                                n_odo_pend = 1'b0;
                                w_emit     = 1'b1;
                                n_kind     = hfpp_pkg::PAIR_ODOMETRY;
                                n_left     = r_odo_left;
                                n_right    = w_value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
        end
        // Load a new result, or clear the register once its beat is taken
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= hfpp_pkg::POS_IDLE;
            r_chan      <= hfpp_pkg::CH_OTHER;
            r_acc       <= '0;
            r_cur_pend  <= 1'b0;
            r_cur_left  <= '0;
            r_odo_pend  <= 1'b0;
            r_odo_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_chan      <= n_chan;
            r_acc       <= n_acc;
            r_cur_pend  <= n_cur_pend;
            r_cur_left  <= n_cur_left;
            r_odo_pend  <= n_odo_pend;
            r_odo_left  <= n_odo_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload; changes only when a new pair is loaded
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pair_kind   = r_kind;
    assign o_left_value  = r_left;
    assign o_right_value = r_right;

endmodule

`default_nettype wire
